/* rtl/sscc_pkg.sv */
// Shared types, widths and codes of the sparse strand cross-correlation block.
package sscc_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int MAX_DELAY   = 1023;
    localparam int POS_W       = 28;
    localparam int CNT_W       = 16;
    localparam int DLY_W       = 10;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int NUM_W       = ADDR_W + 1;
    localparam int S_W         = CNT_W + ADDR_W;
    localparam int SQ_W        = 2 * CNT_W + ADDR_W;
    localparam int V_W         = POS_W + SQ_W;
    localparam int W_W         = 2 * V_W + 32;
    localparam int MCNT_W      = $clog2(V_W + 1);

    localparam logic [1:0] REQ_LOAD_FWD = 2'd0;
    localparam logic [1:0] REQ_LOAD_REV = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;
    localparam logic [1:0] REQ_CLEAR    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_VAR  = 2'd1;
    localparam logic [1:0] ST_BAD_DELAY = 2'd2;

    localparam logic [1:0] CFG_MAX_DIST  = 2'd0;
    localparam logic [1:0] CFG_TOTAL_LEN = 2'd1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] read_count;
        logic [DLY_W-1:0] delay;
    } t_in;

    typedef struct packed {
        logic signed [15:0] correlation;
        logic [1:0]         status;
        logic               overflowed;
    } t_out;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_SF_RD, S_SF_EX, S_SR_RD, S_SR_EX, S_MG_RD, S_MG_EX,
        S_MUL_GO, S_MUL_WAIT, S_SEARCH, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NSFF, OP_SFSF, OP_NSRR, OP_SRSR, OP_NSFR, OP_SFSR, OP_MAG2, OP_VV, OP_LHS
    } t_op;

endpackage

/* rtl/sparse_strand_cross_correlation.sv */
// Top level of the sparse strand cross-correlation block.
// Loads and clears are handled while the block is idle. A query scans the forward
// list, then the reverse list, then merges the two; the serial multiplier then
// runs up to eight products and up to sixteen search steps. The result is held in
// an output register, and a new transaction is accepted once the block has
// finished its current one.
module sparse_strand_cross_correlation
    import sscc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [27:0] i_cfg_data
);

    t_entry r_fwd_mem [MAX_ENTRIES];
    t_entry r_rev_mem [MAX_ENTRIES];
    t_entry r_fwd_q;
    t_entry r_rev_q;

    t_state r_state, n_state;
    t_op    r_op;

    logic [DLY_W-1:0] r_max_dist;
    logic [POS_W-1:0] r_total_len;
    logic [NUM_W-1:0] r_fwd_n, r_rev_n;
    logic [POS_W-1:0] r_fwd_last, r_rev_last;
    logic             r_ovf;

    logic [NUM_W-1:0] r_i, r_j;
    logic [DLY_W-1:0] r_d;
    logic [POS_W-1:0] r_n;
    logic [S_W-1:0]   r_sf, r_sr;
    logic [SQ_W-1:0]  r_sff, r_srr, r_sfr;
    logic [V_W-1:0]   r_pa, r_vf, r_vr, r_mag;
    logic             r_neg;
    logic [W_W-1:0]   r_c2;
    logic [2*V_W-1:0] r_v;
    logic [15:0]      r_lo, r_hi, r_mid;
    logic [31:0]      r_kk;
    logic [15:0]      r_corr;
    logic [1:0]       r_stat;
    logic             r_out_valid;
    t_out             r_out;

    logic           accept, bad_delay, mul_start, mul_done;
    logic [W_W-1:0] mul_a, mul_p;
    logic [V_W-1:0] mul_b, p_lo;
    logic [16:0]    mid_sum;
    logic [15:0]    mid, k;
    logic [POS_W:0] target;
    logic [31:0]    sq_f, sq_r, sq_fr;
    logic           f_in_win, r_in_win, free_out;

    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign free_out    = !r_out_valid || i_out_ready;
    assign bad_delay   = (i_in.delay > r_max_dist) || (i_in.delay > DLY_W'(MAX_DELAY))
                         || ({{(POS_W-DLY_W+1){1'b0}}, i_in.delay} + (POS_W+1)'(2)
                             > {1'b0, r_total_len});
    assign mid_sum     = {1'b0, r_lo} + {1'b0, r_hi} + 17'd1;
    assign mid         = mid_sum[16:1];
    assign k           = {mid[14:0], 1'b0} - 16'd1;
    assign target      = {1'b0, r_fwd_q.pos} + (POS_W+1)'(r_d);
    assign sq_f        = r_fwd_q.cnt * r_fwd_q.cnt;
    assign sq_r        = r_rev_q.cnt * r_rev_q.cnt;
    assign sq_fr       = r_fwd_q.cnt * r_rev_q.cnt;
    assign f_in_win    = (r_fwd_q.pos != '0) && (r_fwd_q.pos <= r_n);
    assign r_in_win    = ({1'b0, r_rev_q.pos} >= (POS_W+1)'(r_d) + (POS_W+1)'(1))
                         && (r_rev_q.pos <= r_total_len);
    assign p_lo        = mul_p[V_W-1:0];

    always_ff @(posedge i_clk) begin
        if (accept && i_in.req_type == REQ_LOAD_FWD && r_fwd_n < NUM_W'(MAX_ENTRIES)) begin
            r_fwd_mem[r_fwd_n[ADDR_W-1:0]] <= '{pos: i_in.position, cnt: i_in.read_count};
        end
        r_fwd_q <= r_fwd_mem[r_i[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.req_type == REQ_LOAD_REV && r_rev_n < NUM_W'(MAX_ENTRIES)) begin
            r_rev_mem[r_rev_n[ADDR_W-1:0]] <= '{pos: i_in.position, cnt: i_in.read_count};
        end
        r_rev_q <= r_rev_mem[r_j[ADDR_W-1:0]];
    end

    always_comb begin
        case (r_op)
            OP_NSFF: begin mul_a = W_W'(r_n);   mul_b = V_W'(r_sff); end
            OP_SFSF: begin mul_a = W_W'(r_sf);  mul_b = V_W'(r_sf);  end
            OP_NSRR: begin mul_a = W_W'(r_n);   mul_b = V_W'(r_srr); end
            OP_SRSR: begin mul_a = W_W'(r_sr);  mul_b = V_W'(r_sr);  end
            OP_NSFR: begin mul_a = W_W'(r_n);   mul_b = V_W'(r_sfr); end
            OP_SFSR: begin mul_a = W_W'(r_sf);  mul_b = V_W'(r_sr);  end
            OP_MAG2: begin mul_a = W_W'(r_mag); mul_b = r_mag;       end
            OP_VV:   begin mul_a = W_W'(r_vf);  mul_b = r_vr;        end
            OP_LHS:  begin mul_a = W_W'(r_v);   mul_b = V_W'(r_kk);  end
            default: begin mul_a = '0;          mul_b = '0;          end
        endcase
    end

    sscc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in.req_type == REQ_QUERY) begin
                    n_state = bad_delay ? S_OUT : S_SF_RD;
                end
            end
            S_SF_RD:   n_state = (r_i >= r_fwd_n) ? S_SR_RD : S_SF_EX;
            S_SF_EX:   n_state = S_SF_RD;
            S_SR_RD:   n_state = (r_j >= r_rev_n) ? S_MG_RD : S_SR_EX;
            S_SR_EX:   n_state = S_SR_RD;
            S_MG_RD:   n_state = (r_i >= r_fwd_n) ? S_MUL_GO : S_MG_EX;
            S_MG_EX:   n_state = S_MG_RD;
            S_MUL_GO:  n_state = S_MUL_WAIT;
            S_MUL_WAIT: begin
                if (mul_done) begin
                    case (r_op)
                        OP_SFSF: n_state = (r_pa <= p_lo) ? S_OUT : S_MUL_GO;
                        OP_SRSR: n_state = (r_pa <= p_lo) ? S_OUT : S_MUL_GO;
                        OP_VV:   n_state = S_SEARCH;
                        OP_LHS:  n_state = S_SEARCH;
                        default: n_state = S_MUL_GO;
                    endcase
                end
            end
            S_SEARCH:  n_state = (r_lo < r_hi) ? S_MUL_GO : S_OUT;
            S_OUT:     n_state = free_out ? S_IDLE : S_OUT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        mul_start  = (r_state == S_MUL_GO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_dist  <= DLY_W'(1);
            r_total_len <= POS_W'(3);
            r_fwd_n     <= '0;
            r_rev_n     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MAX_DIST) begin
                    r_max_dist <= i_cfg_data[DLY_W-1:0];
                end else if (i_cfg_index == CFG_TOTAL_LEN) begin
                    r_total_len <= i_cfg_data;
                end
            end
            if (r_state == S_OUT && free_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_i <= '0;
                    r_j <= '0;
                    if (accept) begin
                        case (i_in.req_type)
                            REQ_LOAD_FWD: begin
                                if (r_fwd_n >= NUM_W'(MAX_ENTRIES)) begin
                                    r_ovf <= 1'b1;
                                end else if (r_fwd_n == '0 || i_in.position > r_fwd_last) begin
                                    r_fwd_n <= r_fwd_n + 1'b1;
                                end
                            end
                            REQ_LOAD_REV: begin
                                if (r_rev_n >= NUM_W'(MAX_ENTRIES)) begin
                                    r_ovf <= 1'b1;
                                end else if (r_rev_n == '0 || i_in.position > r_rev_last) begin
                                    r_rev_n <= r_rev_n + 1'b1;
                                end
                            end
                            REQ_CLEAR: begin
                                r_fwd_n <= '0;
                                r_rev_n <= '0;
                                r_ovf   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SF_RD: begin
                    if (r_i >= r_fwd_n) begin
                        r_i <= '0;
                    end
                end
                S_SF_EX: r_i <= r_i + 1'b1;
                S_SR_RD: begin
                    if (r_j >= r_rev_n) begin
                        r_j <= '0;
                    end
                end
                S_SR_EX: r_j <= r_j + 1'b1;
                S_MG_EX: begin
                    if (!f_in_win) begin
                        r_i <= r_i + 1'b1;
                    end else if (r_j < r_rev_n && {1'b0, r_rev_q.pos} < target) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.req_type == REQ_LOAD_FWD) begin
            if (r_fwd_n < NUM_W'(MAX_ENTRIES) && (r_fwd_n == '0 || i_in.position > r_fwd_last)) begin
                r_fwd_last <= i_in.position;
            end
        end
        if (accept && i_in.req_type == REQ_LOAD_REV) begin
            if (r_rev_n < NUM_W'(MAX_ENTRIES) && (r_rev_n == '0 || i_in.position > r_rev_last)) begin
                r_rev_last <= i_in.position;
            end
        end
        case (r_state)
            S_IDLE: begin
                r_d    <= i_in.delay;
                r_n    <= r_total_len - POS_W'(i_in.delay);
                r_sf   <= '0;
                r_sr   <= '0;
                r_sff  <= '0;
                r_srr  <= '0;
                r_sfr  <= '0;
                r_op   <= OP_NSFF;
                r_corr <= '0;
                r_stat <= ST_BAD_DELAY;
            end
            S_SF_EX: begin
                if (f_in_win) begin
                    r_sf  <= r_sf + S_W'(r_fwd_q.cnt);
                    r_sff <= r_sff + SQ_W'(sq_f);
                end
            end
            S_SR_EX: begin
                if (r_in_win) begin
                    r_sr  <= r_sr + S_W'(r_rev_q.cnt);
                    r_srr <= r_srr + SQ_W'(sq_r);
                end
            end
            S_MG_EX: begin
                if (f_in_win && r_j < r_rev_n && {1'b0, r_rev_q.pos} == target) begin
                    r_sfr <= r_sfr + SQ_W'(sq_fr);
                end
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    case (r_op)
                        OP_NSFF: begin r_pa <= p_lo; r_op <= OP_SFSF; end
                        OP_SFSF: begin
                            r_vf   <= r_pa - p_lo;
                            r_stat <= ST_ZERO_VAR;
                            r_op   <= OP_NSRR;
                        end
                        OP_NSRR: begin r_pa <= p_lo; r_op <= OP_SRSR; end
                        OP_SRSR: begin
                            r_vr   <= r_pa - p_lo;
                            r_stat <= ST_ZERO_VAR;
                            r_op   <= OP_NSFR;
                        end
                        OP_NSFR: begin r_pa <= p_lo; r_op <= OP_SFSR; end
                        OP_SFSR: begin
                            r_neg <= (r_pa < p_lo);
                            r_mag <= (r_pa < p_lo) ? (p_lo - r_pa) : (r_pa - p_lo);
                            r_op  <= OP_MAG2;
                        end
                        OP_MAG2: begin
                            r_c2 <= {mul_p[2*V_W-1:0], 32'd0};
                            r_op <= OP_VV;
                        end
                        OP_VV: begin
                            r_v  <= mul_p[2*V_W-1:0];
                            r_lo <= 16'd0;
                            r_hi <= 16'd32768;
                            r_op <= OP_LHS;
                        end
                        OP_LHS: begin
                            if (mul_p <= r_c2) begin
                                r_lo <= r_mid;
                            end else begin
                                r_hi <= r_mid - 16'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                r_mid <= mid;
                r_kk  <= k * k;
                r_stat <= ST_OK;
                if (r_neg) begin
                    r_corr <= 16'd0 - r_lo;
                end else begin
                    r_corr <= (r_lo > 16'd32767) ? 16'd32767 : r_lo;
                end
            end
            S_OUT: begin
                if (free_out) begin
                    r_out.correlation <= (r_stat == ST_OK) ? r_corr : 16'd0;
                    r_out.status      <= r_stat;
                    r_out.overflowed  <= r_ovf;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/sscc_mul.sv */
// Shift-and-add serial multiplier, one multiplier bit per cycle.
module sscc_mul
    import sscc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W_W-1:0] i_a,
    input  logic [V_W-1:0] i_b,
    output logic           o_done,
    output logic [W_W-1:0] o_p
);

    logic [W_W-1:0]    r_a;
    logic [V_W-1:0]    r_b;
    logic [W_W-1:0]    r_p;
    logic [MCNT_W-1:0] r_cnt;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= MCNT_W'(V_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_cnt != '0) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= {r_a[W_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[V_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

/* tb/sv/tb_sparse_strand_cross_correlation.sv */
// Self-checking testbench for the sparse strand cross-correlation block.
module tb_sparse_strand_cross_correlation;
    import sscc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES = 6000;
    localparam int FILL_LOADS = 16;

    typedef logic [319:0] t_wide;

    typedef struct {
        t_in        req;
        bit         typed;
        logic [1:0] status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_item = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [27:0] cfg_data = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out        o_out;
    logic        o_cfg_ready;

    logic [27:0] fwd_pos[$];
    logic [15:0] fwd_cnt[$];
    logic [27:0] rev_pos[$];
    logic [15:0] rev_cnt[$];
    bit          lost_load;
    logic [9:0]  cur_max_dist;
    logic [27:0] cur_total_len;

    t_out pending_coeffs[$];
    int   failures = 0;
    int   idle_cycles = 0;
    bit   hold_req = 0;
    bit   steady = 0;
    bit   sender_gaps = 1;

    t_row rows[$];

    sparse_strand_cross_correlation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in(in_item),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out(o_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** sparse_strand_cross_correlation: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void strand_load(ref logic [27:0] pos[$], ref logic [15:0] cnt[$],
                                        input logic [27:0] p, input logic [15:0] c);
        if (pos.size() >= MAX_ENTRIES) begin
            lost_load = 1;
        end else if (pos.size() == 0 || p > pos[$]) begin
            pos.push_back(p);
            cnt.push_back(c);
        end
    endfunction

    function automatic bit correlate_request(input t_in x, output t_out r);
        logic [63:0] d, tl, n, sf, sr;
        t_wide sff, srr, sfr, a, b, vf, vr, mag, c2, v, k;
        bit neg;
        int j, lo, hi, mid;
        r = '0;
        case (x.req_type)
            REQ_LOAD_FWD: begin
                strand_load(fwd_pos, fwd_cnt, x.position, x.read_count);
                return 0;
            end
            REQ_LOAD_REV: begin
                strand_load(rev_pos, rev_cnt, x.position, x.read_count);
                return 0;
            end
            REQ_CLEAR: begin
                fwd_pos.delete(); fwd_cnt.delete();
                rev_pos.delete(); rev_cnt.delete();
                lost_load = 0;
                return 0;
            end
            default: ;
        endcase
        r.overflowed = lost_load;
        d = x.delay;
        tl = cur_total_len;
        if (d > cur_max_dist || d > MAX_DELAY || d + 2 > tl) begin
            r.status = ST_BAD_DELAY;
            return 1;
        end
        n = tl - d;
        sf = 0; sr = 0; sff = 0; srr = 0; sfr = 0;
        foreach (fwd_pos[i]) begin
            if (fwd_pos[i] >= 1 && fwd_pos[i] <= n) begin
                sf += fwd_cnt[i];
                sff += t_wide'(fwd_cnt[i]) * t_wide'(fwd_cnt[i]);
            end
        end
        foreach (rev_pos[i]) begin
            if (rev_pos[i] >= d + 1 && rev_pos[i] <= tl) begin
                sr += rev_cnt[i];
                srr += t_wide'(rev_cnt[i]) * t_wide'(rev_cnt[i]);
            end
        end
        j = 0;
        foreach (fwd_pos[i]) begin
            if (fwd_pos[i] >= 1 && fwd_pos[i] <= n) begin
                while (j < rev_pos.size() && 64'(rev_pos[j]) < 64'(fwd_pos[i]) + d) j++;
                if (j < rev_pos.size() && 64'(rev_pos[j]) == 64'(fwd_pos[i]) + d)
                    sfr += t_wide'(fwd_cnt[i]) * t_wide'(rev_cnt[j]);
            end
        end
        a = t_wide'(n) * sff;
        b = t_wide'(sf) * t_wide'(sf);
        if (a <= b) begin
            r.status = ST_ZERO_VAR;
            return 1;
        end
        vf = a - b;
        a = t_wide'(n) * srr;
        b = t_wide'(sr) * t_wide'(sr);
        if (a <= b) begin
            r.status = ST_ZERO_VAR;
            return 1;
        end
        vr = a - b;
        a = t_wide'(n) * sfr;
        b = t_wide'(sf) * t_wide'(sr);
        neg = a < b;
        mag = neg ? b - a : a - b;
        c2 = (mag * mag) << 32;
        v = vf * vr;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            k = t_wide'(2 * mid - 1);
            if (k * k * v <= c2) lo = mid;
            else hi = mid - 1;
        end
        if (neg) r.correlation = 16'(65536 - lo);
        else r.correlation = (lo > 32767) ? 16'sd32767 : 16'(lo);
        r.status = ST_OK;
        return 1;
    endfunction

    task automatic send(input t_in x, input bit typed = 0, input logic [1:0] st = ST_OK);
        t_out r;
        int gap;
        in_valid <= 1'b1;
        in_item <= x;
        do @(posedge i_clk); while (!o_in_ready);
        if (correlate_request(x, r)) begin
            if (typed) pending_coeffs.push_back('{16'sd0, st, 1'b0});
            else pending_coeffs.push_back(r);
        end
        gap = 0;
        if (sender_gaps && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_coeffs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [27:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_DIST) cur_max_dist = data[9:0];
        else if (idx == CFG_TOTAL_LEN) cur_total_len = data;
    endtask

    function automatic t_row mk(logic [1:0] t, int p, int c, int d,
                                bit typed = 0, logic [1:0] st = ST_OK);
        t_row w;
        w.req = '{t, 28'(p), 16'(c), 10'(d)};
        w.typed = typed;
        w.status = st;
        return w;
    endfunction

    task automatic random_phase(input int items);
        t_in x;
        int sel, span;
        logic [27:0] last;
        for (int i = 0; i < items; i++) begin
            x = '0;
            sel = $urandom_range(0, 99);
            x.read_count = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
            if (sel < 6) begin
                x.req_type = REQ_CLEAR;
            end else if (sel < 62) begin
                x.req_type = (sel < 34) ? REQ_LOAD_FWD : REQ_LOAD_REV;
                if (x.req_type == REQ_LOAD_FWD) last = (fwd_pos.size() != 0) ? fwd_pos[$] : 0;
                else last = (rev_pos.size() != 0) ? rev_pos[$] : 0;
                x.position = last + 28'($urandom_range(1, 4));
                if ($urandom_range(0, 9) == 0) x.position = 28'($urandom);
            end else if (sel < 92) begin
                x.req_type = REQ_QUERY;
                span = (cur_max_dist < cur_total_len - 2) ? cur_max_dist : cur_total_len - 2;
                x.delay = 10'($urandom_range(0, span));
            end else begin
                x = t_in'({$urandom, $urandom, $urandom});
            end
            send(x);
        end
    endtask

    initial begin
        t_out got;
        t_out want;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && out_ready) begin
                got = o_out;
                if (pending_coeffs.size() == 0) begin
                    $error("unexpected result: correlation=%0d status=%0d overflowed=%0d",
                           got.correlation, got.status, got.overflowed);
                    failures++;
                end else begin
                    want = pending_coeffs.pop_front();
                    if (got.correlation !== want.correlation) begin
                        $error("correlation: expected %0d, got %0d",
                               want.correlation, got.correlation);
                        failures++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        failures++;
                    end
                    if (got.overflowed !== want.overflowed) begin
                        $error("overflowed: expected %0d, got %0d",
                               want.overflowed, got.overflowed);
                        failures++;
                    end
                end
            end
            if (hold_req) begin
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (steady) begin
                out_ready <= 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(20, 150)) @(posedge i_clk);
            end else begin
                out_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        cur_max_dist = 10'd1;
        cur_total_len = 28'd3;
        lost_load = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(mk(REQ_QUERY, 0, 0, 0, 1, ST_ZERO_VAR));
        rows.push_back(mk(REQ_QUERY, 0, 0, 2, 1, ST_BAD_DELAY));
        rows.push_back(mk(REQ_LOAD_FWD, 0, 5, 0));
        rows.push_back(mk(REQ_LOAD_FWD, 1, 65535, 0));
        rows.push_back(mk(REQ_LOAD_FWD, 3, 0, 0));
        rows.push_back(mk(REQ_LOAD_FWD, 3, 7, 0));
        rows.push_back(mk(REQ_LOAD_FWD, 2, 9, 0));
        rows.push_back(mk(REQ_LOAD_FWD, 5, 9, 0));
        rows.push_back(mk(REQ_LOAD_FWD, 20, 12, 0));
        rows.push_back(mk(REQ_LOAD_REV, 2, 4, 0));
        rows.push_back(mk(REQ_LOAD_REV, 4, 65535, 0));
        rows.push_back(mk(REQ_LOAD_REV, 6, 1, 0));
        rows.push_back(mk(REQ_LOAD_REV, 20, 3, 0));
        rows.push_back(mk(REQ_QUERY, 0, 0, 0));
        rows.push_back(mk(REQ_QUERY, 0, 0, 1));
        rows.push_back(mk(REQ_QUERY, 0, 0, 2));
        rows.push_back(mk(REQ_QUERY, 0, 0, 18));
        rows.push_back(mk(REQ_QUERY, 0, 0, 19, 1, ST_BAD_DELAY));
        rows.push_back(mk(REQ_QUERY, 0, 0, 1023, 1, ST_BAD_DELAY));
        rows.push_back(mk(REQ_CLEAR, 0, 0, 0));
        rows.push_back(mk(REQ_QUERY, 0, 0, 0, 1, ST_ZERO_VAR));
        rows.push_back(mk(REQ_LOAD_FWD, 268435455, 65535, 0));
        rows.push_back(mk(REQ_LOAD_REV, 268435455, 1, 0));
        rows.push_back(mk(REQ_QUERY, 0, 0, 0, 1, ST_ZERO_VAR));
        rows.push_back(mk(REQ_CLEAR, 0, 0, 0));

        foreach (rows[i]) begin
            if (i == 2) begin
                drain();
                cfg_write(CFG_MAX_DIST, 28'd1023);
                cfg_write(CFG_TOTAL_LEN, 28'd20);
            end
            if (i == 13) hold_req = 1;
            send(rows[i].req, rows[i].typed, rows[i].status);
        end
        drain();

        cfg_write(CFG_TOTAL_LEN, 28'd5000);
        cfg_write(CFG_UNUSED, 28'($urandom));
        sender_gaps = 0;
        for (int i = 0; i < FILL_LOADS; i++)
            send('{REQ_LOAD_FWD, 28'(i + 1), 16'($urandom), 10'd0});
        send('{REQ_LOAD_REV, 28'd5, 16'd3, 10'd0});
        send('{REQ_LOAD_REV, 28'd9, 16'd8, 10'd0});
        send('{REQ_QUERY, 28'd0, 16'd0, 10'd4});
        send('{REQ_CLEAR, 28'd0, 16'd0, 10'd0});
        send('{REQ_QUERY, 28'd0, 16'd0, 10'd0});
        sender_gaps = 1;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin cfg_write(CFG_MAX_DIST, 28'd1); cfg_write(CFG_TOTAL_LEN, 28'd3); end
                1: begin
                    cfg_write(CFG_MAX_DIST, 28'd1023);
                    cfg_write(CFG_TOTAL_LEN, 28'd268435455);
                end
                default: begin
                    cfg_write(CFG_MAX_DIST, 28'($urandom_range(1, 40)));
                    cfg_write(CFG_TOTAL_LEN, 28'($urandom_range(3, 60)));
                end
            endcase
            steady = (ph == 3);
            if (ph == 4) hold_req = 1;
            random_phase(12);
            drain();
        end

        drain();
        if (failures == 0) begin
            $display("** sparse_strand_cross_correlation: PASSED **");
        end else begin
            $display("** sparse_strand_cross_correlation: FAILED **");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/sscc_pkg.sv
rtl/sscc_mul.sv
rtl/sparse_strand_cross_correlation.sv
tb/sv/tb_sparse_strand_cross_correlation.sv
